### design/spt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types and constants of the sensor presence table.
// ----------------------------------------------------------------------------
package spt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int OP_W     = 2;
    localparam int SERIAL_W = 32;
    localparam int MODEL_W  = 2;
    localparam int TIME_W   = 32;
    localparam int BATT_W   = 7;
    localparam int SIG_W    = 8;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int ONLINE_W = 7;
    localparam int WINDOW_W = 16;
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_TOUCH   = 2'd0;
    localparam logic [OP_W-1:0] OP_BATTERY = 2'd1;
    localparam logic [OP_W-1:0] OP_SIGNAL  = 2'd2;
    localparam logic [OP_W-1:0] OP_COUNT   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_COUNT   = 3'd4;

    localparam logic [MODEL_W-1:0] MODEL_UNKNOWN = 2'd0;
    localparam logic [MODEL_W-1:0] MODEL_FIRST   = 2'd1;

    localparam logic [BATT_W-1:0]   BATTERY_MAX  = 7'd100;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd60;

    // register index, taken from paddr[2]
    localparam logic REG_ONLINE_WINDOW = 1'b0;

    typedef struct packed {
        logic [SERIAL_W-1:0] serial;
        logic [MODEL_W-1:0]  model;
        logic                seen;
        logic [TIME_W-1:0]   seen_time;
        logic                batt_flag;
        logic [BATT_W-1:0]   batt_level;
        logic                sig_flag;
        logic [SIG_W-1:0]    sig_level;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    typedef struct packed {
        logic [6:0]          pad;
        logic [SIG_W-1:0]    signal_dbm;
        logic [BATT_W-1:0]   battery_percent;
        logic [TIME_W-1:0]   now;
        logic [MODEL_W-1:0]  hint;
        logic [SERIAL_W-1:0] serial;
    } s_data_t;

    typedef struct packed {
        logic                pad;
        logic [ONLINE_W-1:0] online_count;
        logic [MODEL_W-1:0]  entry_model;
        logic [SLOT_W-1:0]   slot;
    } m_data_t;

    typedef struct packed {
        logic                load;
        logic                scan;
        logic                commit_hit;
        logic                commit_new;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
    } cmd_t;

    typedef struct packed {
        logic is_count;
        logic serial_zero;
        logic found;
        logic scan_done;
        logic full;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

### design/sensor_presence_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_presence_table
// Search: N = rows in use (0..64), read by the one-row-per-cycle scan over
//   the single read port.
// Flow: one transaction in flight; the next can be taken once the result
//   is in the output register.
// Reset: synchronous, active low; clears row count and online_window to 60.
//   Row RAM contents are not cleared; rows are written on append.
// ----------------------------------------------------------------------------
module sensor_presence_table (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // s_tdata: serial, hint, now, battery_percent, signal_dbm
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [spt_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: op
    input  wire logic [spt_pkg::OP_W-1:0]          s_tuser,
    // m_tdata: slot, entry_model, online_count
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [spt_pkg::M_TDATA_W-1:0]     m_tdata,
    // m_tuser: status
    output logic      [spt_pkg::STATUS_W-1:0]      m_tuser,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [spt_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [spt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [spt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);
    import spt_pkg::*;

    logic [WINDOW_W-1:0] window_reg;
    cmd_t                cmd;
    stat_t               stat;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_ONLINE_WINDOW) begin
            window_reg <= pwdata[WINDOW_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ONLINE_WINDOW) ? APB_DATA_W'(window_reg) : '0;

    spt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spt_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .window   (window_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a transaction is in progress");

    a_append_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit_new |-> !stat.full)
        else $error("row appended to a full table");

    a_result_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> stat.out_free)
        else $error("result overwrote a pending output");

    a_ignored_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_IGNORED) |-> m_tdata == '0)
        else $error("ignored update carries nonzero fields");
`endif

endmodule
`default_nettype wire

### design/spt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module spt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### design/spt_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spt_datapath
// Row storage, sequential search and count, row update and result register.
// ----------------------------------------------------------------------------
module spt_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire spt_pkg::cmd_t                   cmd,
    output spt_pkg::stat_t                       stat,
    input  wire logic [spt_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [spt_pkg::OP_W-1:0]        s_tuser,
    input  wire logic [spt_pkg::WINDOW_W-1:0]    window,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [spt_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic      [spt_pkg::STATUS_W-1:0]    m_tuser
);
    import spt_pkg::*;

    s_data_t               s_in;
    logic [OP_W-1:0]       op_reg;
    logic [SERIAL_W-1:0]   serial_reg;
    logic [MODEL_W-1:0]    hint_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [BATT_W-1:0]     batt_reg;
    logic [SIG_W-1:0]      sig_reg;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      addr_reg;
    logic                  rvalid_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic                  found_reg;
    row_t                  hit_row_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [CNT_W-1:0]      acc_reg;
    logic [IDX_W-1:0]      tgt_idx_reg;
    logic [MODEL_W-1:0]    tgt_model_reg;
    logic                  m_tvalid_reg;
    logic [STATUS_W-1:0]   m_tuser_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic [ROW_W-1:0]      ram_rdata;
    row_t                  rd_row;
    logic                  more;
    logic                  issue;
    logic                  is_count;
    logic                  match;
    logic [TIME_W-1:0]     diff;
    logic                  online;
    logic [BATT_W-1:0]     batt_sat;
    logic [MODEL_W-1:0]    upd_model;
    row_t                  upd_row;
    row_t                  new_row;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    row_t                  ram_wdata;
    m_data_t               res;

    assign s_in     = s_data_t'(s_tdata);
    assign rd_row   = row_t'(ram_rdata);
    assign more     = addr_reg < count_reg;
    assign issue    = cmd.scan && !found_reg && more;
    assign is_count = op_reg == OP_COUNT;
    assign match    = rvalid_reg && !is_count && !found_reg
                   && (rd_row.serial == serial_reg);
    assign diff     = now_reg - rd_row.seen_time;
    assign online   = rd_row.seen && (diff[TIME_W-1] || (diff < TIME_W'(window)));
    assign batt_sat = (batt_reg > BATTERY_MAX) ? BATTERY_MAX : batt_reg;

    always_comb begin
        upd_model = hit_row_reg.model;
        if (upd_model == MODEL_UNKNOWN && hint_reg != MODEL_UNKNOWN) begin
            upd_model = hint_reg;
        end
        if (hint_reg == MODEL_FIRST) begin
            upd_model = MODEL_FIRST;
        end
    end

    always_comb begin
        upd_row           = hit_row_reg;
        upd_row.model     = upd_model;
        upd_row.seen      = 1'b1;
        upd_row.seen_time = now_reg;
        if (op_reg == OP_BATTERY) begin
            upd_row.batt_flag  = 1'b1;
            upd_row.batt_level = batt_sat;
        end
        if (op_reg == OP_SIGNAL) begin
            upd_row.sig_flag  = 1'b1;
            upd_row.sig_level = sig_reg;
        end
    end

    always_comb begin
        new_row            = '0;
        new_row.serial     = serial_reg;
        new_row.model      = hint_reg;
        new_row.seen       = 1'b1;
        new_row.seen_time  = now_reg;
        if (op_reg == OP_BATTERY) begin
            new_row.batt_flag  = 1'b1;
            new_row.batt_level = batt_sat;
        end
        if (op_reg == OP_SIGNAL) begin
            new_row.sig_flag  = 1'b1;
            new_row.sig_level = sig_reg;
        end
    end

    assign ram_we    = cmd.commit_hit || cmd.commit_new;
    assign ram_waddr = cmd.commit_new ? count_reg[IDX_W-1:0] : hit_idx_reg;
    assign ram_wdata = cmd.commit_new ? new_row : upd_row;

    spt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_DEPTH)
    ) u_rows (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (addr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        res = '0;
        case (cmd.res_status)
            ST_UPDATED, ST_ADDED: begin
                res.slot        = SLOT_W'(tgt_idx_reg);
                res.entry_model = tgt_model_reg;
            end
            ST_COUNT: begin
                res.online_count = ONLINE_W'(acc_reg);
            end
            default: begin
            end
        endcase
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= s_tuser;
            serial_reg <= s_in.serial;
            hint_reg   <= s_in.hint;
            now_reg    <= s_in.now;
            batt_reg   <= s_in.battery_percent;
            sig_reg    <= s_in.signal_dbm;
        end
    end

    // scan control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg   <= '0;
            rvalid_reg <= 1'b0;
            found_reg  <= 1'b0;
            acc_reg    <= '0;
            count_reg  <= '0;
        end else begin
            if (cmd.load) begin
                addr_reg   <= '0;
                rvalid_reg <= 1'b0;
                found_reg  <= 1'b0;
                acc_reg    <= '0;
            end else begin
                if (issue) begin
                    addr_reg <= addr_reg + 1'b1;
                end
                rvalid_reg <= issue;
                if (match) begin
                    found_reg <= 1'b1;
                end
                if (rvalid_reg && is_count && online) begin
                    acc_reg <= acc_reg + 1'b1;
                end
            end
            if (cmd.commit_new) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= addr_reg[IDX_W-1:0];
        if (match) begin
            hit_row_reg <= rd_row;
            hit_idx_reg <= cmp_idx_reg;
        end
        if (cmd.commit_hit) begin
            tgt_idx_reg   <= hit_idx_reg;
            tgt_model_reg <= upd_model;
        end
        if (cmd.commit_new) begin
            tgt_idx_reg   <= count_reg[IDX_W-1:0];
            tgt_model_reg <= hint_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            m_tuser_reg <= cmd.res_status;
            m_tdata_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    assign stat.is_count    = is_count;
    assign stat.serial_zero = serial_reg == '0;
    assign stat.found       = found_reg;
    assign stat.scan_done   = !rvalid_reg && !more;
    assign stat.full        = count_reg == CNT_W'(TABLE_DEPTH);
    assign stat.out_free    = !m_tvalid_reg || m_tready;

endmodule
`default_nettype wire

### design/spt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spt_ctrl
// Sequencer: accept, table scan, row commit, result hand-off.
// ----------------------------------------------------------------------------
module spt_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire spt_pkg::stat_t stat,
    output spt_pkg::cmd_t       cmd
);
    import spt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_HIT    = 5'b00100,
        S_APPEND = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [STATUS_W-1:0] kind_reg, kind_next;

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.res_status = kind_reg;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.found) begin
                    state_next = S_HIT;
                end else if (stat.scan_done) begin
                    if (stat.is_count) begin
                        kind_next  = ST_COUNT;
                        state_next = S_RESULT;
                    end else if (stat.serial_zero) begin
                        kind_next  = ST_IGNORED;
                        state_next = S_RESULT;
                    end else if (stat.full) begin
                        kind_next  = ST_FULL;
                        state_next = S_RESULT;
                    end else begin
                        state_next = S_APPEND;
                    end
                end
            end
            S_HIT: begin
                cmd.commit_hit = 1'b1;
                kind_next      = ST_UPDATED;
                state_next     = S_RESULT;
            end
            S_APPEND: begin
                cmd.commit_new = 1'b1;
                kind_next      = ST_ADDED;
                state_next     = S_RESULT;
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            kind_reg  <= ST_UPDATED;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule
`default_nettype wire
